@@ src/zsc_pkg.sv @@
// ----------------------------------------------------------------------------
// zsc_pkg: shared definitions for the Z80 subset bus step core
// Request kinds, execution phases, prefix states, stop states and flag bit positions.
// ----------------------------------------------------------------------------
package zsc_pkg;

    typedef enum logic [2:0] {
        KIND_FETCH  = 3'd0,
        KIND_MEMRD  = 3'd1,
        KIND_MEMWR  = 3'd2,
        KIND_IORD   = 3'd3,
        KIND_IOWR   = 3'd4,
        KIND_HALTED = 3'd5,
        KIND_ERROR  = 3'd6
    } req_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OPC    = 3'd1,
        PH_OP1    = 3'd2,
        PH_OP2    = 3'd3,
        PH_WRDONE = 3'd4,
        PH_MEMRD  = 3'd5,
        PH_IORD   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        PFX_NONE  = 3'd0,
        PFX_IDX   = 3'd1,
        PFX_CBED  = 3'd2,
        PFX_DISP  = 3'd3,
        PFX_DONE  = 3'd4
    } prefix_t;

    typedef enum logic [1:0] {
        STOP_RUN   = 2'd0,
        STOP_HALT  = 2'd1,
        STOP_ERROR = 2'd2
    } stop_t;

    localparam int FS  = 7;
    localparam int FZ  = 6;
    localparam int FH  = 4;
    localparam int FPV = 2;
    localparam int FN  = 1;
    localparam int FC  = 0;

endpackage

@@ src/z80_subset_core_bus_step_unit.sv @@
// ----------------------------------------------------------------------------
// z80_subset_core_bus_step_unit
// Z80 subset core that issues one bus request per input transaction.
// ----------------------------------------------------------------------------
// Each slave transaction carries the byte answering the previous bus request;
// the core answers with exactly one master transaction holding the next
// request (fetch, memory or I/O access, halted or error) together with the pc,
// accumulator and flags after the step. One transaction is taken per clock
// cycle while the master side keeps taking results: the accepted byte is held
// in an input register, decoded and executed by short combinational logic, and
// the result lands in an output register. The first transaction after reset
// loads start_pc and starts the first fetch; start_pc may be written at any
// time but only takes effect at that first step. Halt and unsupported opcodes
// are sticky until reset.
module z80_subset_core_bus_step_unit
    import zsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // read_data [7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tuser,   // req_kind [2:0], zero [7:3]
    output logic [63:0] m_tdata    // req_addr, req_data, pc_now, acc_now, flags_now, zero
);

    logic [15:0] start_pc_reg;
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  rb_reg, rc_reg, rd_reg, re_reg, rh_reg, rl_reg, rf_reg, ra_reg;
    logic [7:0]  rb_next, rc_next, rd_next, re_next, rh_next, rl_next, rf_next, ra_next;
    logic [7:0]  alt_a_reg, alt_f_reg, alt_a_next, alt_f_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  op_reg, op_next, imm_reg, imm_next;
    prefix_t     pfx_reg, pfx_next;
    stop_t       stop_reg, stop_next;

    // Input register stage.
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    // Output register stage.
    logic        out_valid_reg;
    req_kind_t   out_kind_reg, kind_c;
    logic [15:0] out_addr_reg, addr_c;
    logic [7:0]  out_data_reg, data_c;

    logic out_free, exec_go;
    assign out_free  = !out_valid_reg || m_tready;
    assign exec_go   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {5'd0, out_kind_reg};
    assign m_tdata  = {8'd0, rf_reg, ra_reg, pc_reg, out_data_reg, out_addr_reg};

    logic [15:0] bc, de, hl, t16, sum16;
    logic [16:0] add17;
    logic [7:0]  v, t8, cmp_r;
    logic [3:0]  op_k;
    logic        take;

    always_comb begin
        v = in_data_reg;
        pc_next = pc_reg;
        rb_next = rb_reg; rc_next = rc_reg; rd_next = rd_reg; re_next = re_reg;
        rh_next = rh_reg; rl_next = rl_reg; rf_next = rf_reg; ra_next = ra_reg;
        alt_a_next = alt_a_reg; alt_f_next = alt_f_reg;
        phase_next = phase_reg; op_next = op_reg; imm_next = imm_reg;
        pfx_next = pfx_reg; stop_next = stop_reg;
        kind_c = KIND_FETCH; addr_c = pc_reg; data_c = 8'd0;
        bc = {rb_reg, rc_reg}; de = {rd_reg, re_reg}; hl = {rh_reg, rl_reg};
        t16 = 16'd0; sum16 = 16'd0; add17 = 17'd0; t8 = 8'd0; cmp_r = 8'd0;
        op_k = 4'd0; take = 1'b0;
        // op_k: 0 fetch next opcode, 1 fetch operand, 2 fetch second operand,
        // 3 request already set, 4 halt, 5 error
        if (stop_reg != STOP_RUN) begin
            op_k = (stop_reg == STOP_HALT) ? 4'd4 : 4'd5;
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    pc_next  = start_pc_reg;
                    pfx_next = PFX_NONE;
                    op_k = 4'd0;
                end
                PH_OPC: begin
                    if (v inside {8'hcb, 8'hdd, 8'hfd, 8'hed}) begin
                        if (pfx_reg == PFX_NONE)
                            pfx_next = (v == 8'hdd || v == 8'hfd) ? PFX_IDX : PFX_CBED;
                        else if (pfx_reg == PFX_IDX && v == 8'hcb)
                            pfx_next = PFX_DISP;
                        else
                            pfx_next = PFX_DONE;
                        op_k = 4'd0;
                    end else if (pfx_reg == PFX_DISP) begin
                        pfx_next = PFX_DONE;
                        op_k = 4'd0;
                    end else if (pfx_reg != PFX_NONE) begin
                        op_k = 4'd5;
                    end else begin
                        op_next = v;
                        op_k = 4'd0;
                        case (v)
                            8'h00: ;
                            8'h02, 8'h12: begin
                                op_k = 4'd3; phase_next = PH_WRDONE;
                                kind_c = KIND_MEMWR; addr_c = (v == 8'h02) ? bc : de;
                                data_c = ra_reg;
                            end
                            8'h0a: begin
                                op_k = 4'd3; phase_next = PH_MEMRD;
                                kind_c = KIND_MEMRD; addr_c = bc;
                            end
                            8'h03: {rb_next, rc_next} = bc + 16'd1;
                            8'h0b: {rb_next, rc_next} = bc - 16'd1;
                            8'h13: {rd_next, re_next} = de + 16'd1;
                            8'h04, 8'h0c, 8'h14: begin
                                t8 = (v == 8'h04) ? rb_reg : (v == 8'h0c) ? rc_reg : rd_reg;
                                rf_next[FH]  = (t8[3:0] == 4'hf);
                                rf_next[FPV] = (t8 == 8'h7f);
                                t8 = t8 + 8'd1;
                                rf_next[FN] = 1'b0;
                                rf_next[FZ] = (t8 == 8'd0);
                                rf_next[FS] = t8[7];
                                if (v == 8'h04) rb_next = t8;
                                else if (v == 8'h0c) rc_next = t8;
                                else rd_next = t8;
                            end
                            8'h05, 8'h0d, 8'h15: begin
                                t8 = (v == 8'h05) ? rb_reg : (v == 8'h0d) ? rc_reg : rd_reg;
                                t8 = t8 - 8'd1;
                                rf_next[FPV] = (t8 == 8'h7f);
                                rf_next[FH]  = (t8[3:0] == 4'hf);
                                rf_next[FN] = 1'b1;
                                rf_next[FZ] = (t8 == 8'd0);
                                rf_next[FS] = t8[7];
                                if (v == 8'h05) rb_next = t8;
                                else if (v == 8'h0d) rc_next = t8;
                                else rd_next = t8;
                            end
                            8'h07: begin
                                ra_next = {ra_reg[6:0], ra_reg[7]};
                                rf_next[FC] = ra_reg[7]; rf_next[FN] = 1'b0; rf_next[FH] = 1'b0;
                            end
                            8'h0f: begin
                                ra_next = {ra_reg[0], ra_reg[7:1]};
                                rf_next[FC] = ra_reg[0]; rf_next[FN] = 1'b0; rf_next[FH] = 1'b0;
                            end
                            8'h17: begin
                                ra_next = {ra_reg[6:0], rf_reg[FC]};
                                rf_next[FC] = ra_reg[7]; rf_next[FN] = 1'b0; rf_next[FH] = 1'b0;
                            end
                            8'h08: begin
                                alt_a_next = ra_reg; alt_f_next = rf_reg;
                                ra_next = alt_a_reg; rf_next = alt_f_reg;
                            end
                            8'h09, 8'h19: begin
                                t16 = (v == 8'h09) ? bc : de;
                                add17 = {1'b0, hl} + {1'b0, t16};
                                sum16 = add17[15:0];
                                rf_next[FC] = add17[16];
                                rf_next[FN] = 1'b0;
                                rf_next[FH] = hl[12] ^ t16[12] ^ sum16[12];
                                {rh_next, rl_next} = sum16;
                            end
                            8'hb7: begin
                                rf_next[FC] = 1'b0; rf_next[FH] = 1'b0; rf_next[FN] = 1'b0;
                                rf_next[FZ] = (ra_reg == 8'd0);
                                rf_next[FPV] = ~(^ra_reg);
                                rf_next[FS] = ra_reg[7];
                            end
                            8'h10: begin
                                rb_next = rb_reg - 8'd1;
                                op_k = 4'd1;
                            end
                            8'h01, 8'h06, 8'h0e, 8'h11, 8'h16, 8'h18,
                            8'h28, 8'h32, 8'h3e, 8'hd3, 8'hdb, 8'hfe: op_k = 4'd1;
                            8'h76: op_k = 4'd4;
                            default: op_k = 4'd5;
                        endcase
                    end
                end
                PH_OP1: begin
                    op_k = 4'd0;
                    case (op_reg)
                        8'h01: begin rc_next = v; op_k = 4'd2; end
                        8'h11: begin re_next = v; op_k = 4'd2; end
                        8'h32: begin imm_next = v; op_k = 4'd2; end
                        8'h06: rb_next = v;
                        8'h0e: rc_next = v;
                        8'h16: rd_next = v;
                        8'h3e: ra_next = v;
                        8'hfe: begin
                            cmp_r = ra_reg - v;
                            rf_next[FC]  = (ra_reg < v);
                            rf_next[FH]  = (ra_reg[3:0] < v[3:0]);
                            rf_next[FN]  = 1'b1;
                            rf_next[FZ]  = (cmp_r == 8'd0);
                            rf_next[FPV] = (ra_reg[7] ^ v[7]) & (ra_reg[7] ^ cmp_r[7]);
                            rf_next[FS]  = cmp_r[7];
                        end
                        8'h10, 8'h18, 8'h28: begin
                            take = (op_reg == 8'h18) || (op_reg == 8'h10 && rb_reg != 8'd0) ||
                                   (op_reg == 8'h28 && rf_reg[FZ]);
                            if (take) pc_next = pc_reg + {{8{v[7]}}, v};
                        end
                        8'hd3: begin
                            op_k = 4'd3; phase_next = PH_WRDONE;
                            kind_c = KIND_IOWR; addr_c = {ra_reg, v}; data_c = ra_reg;
                        end
                        8'hdb: begin
                            op_k = 4'd3; phase_next = PH_IORD;
                            kind_c = KIND_IORD; addr_c = {ra_reg, v};
                        end
                        default: op_k = 4'd5;
                    endcase
                end
                PH_OP2: begin
                    op_k = 4'd0;
                    case (op_reg)
                        8'h01: rb_next = v;
                        8'h11: rd_next = v;
                        8'h32: begin
                            op_k = 4'd3; phase_next = PH_WRDONE;
                            kind_c = KIND_MEMWR; addr_c = {v, imm_reg}; data_c = ra_reg;
                        end
                        default: op_k = 4'd5;
                    endcase
                end
                PH_MEMRD, PH_IORD: begin
                    ra_next = v;
                    op_k = 4'd0;
                end
                PH_WRDONE: op_k = 4'd0;
                default: op_k = 4'd5;
            endcase
        end
        case (op_k)
            4'd0, 4'd1, 4'd2: begin
                kind_c = KIND_FETCH; addr_c = pc_next; data_c = 8'd0;
                pc_next = pc_next + 16'd1;
                phase_next = (op_k == 4'd0) ? PH_OPC : (op_k == 4'd1) ? PH_OP1 : PH_OP2;
            end
            4'd3: ;
            4'd4: begin
                stop_next = STOP_HALT; kind_c = KIND_HALTED; addr_c = 16'd0; data_c = 8'd0;
            end
            default: begin
                stop_next = STOP_ERROR; kind_c = KIND_ERROR; addr_c = 16'd0; data_c = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pc_reg <= 16'd0;
            pc_reg <= 16'd0;
            rb_reg <= 8'd0; rc_reg <= 8'd0; rd_reg <= 8'd0; re_reg <= 8'd0;
            rh_reg <= 8'd0; rl_reg <= 8'd0; rf_reg <= 8'd0; ra_reg <= 8'd0;
            alt_a_reg <= 8'd0; alt_f_reg <= 8'd0;
            phase_reg <= PH_IDLE; op_reg <= 8'd0; imm_reg <= 8'd0;
            pfx_reg <= PFX_NONE; stop_reg <= STOP_RUN;
            in_valid_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) start_pc_reg <= cfg_data;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_tdata;
            end else if (exec_go) begin
                in_valid_reg <= 1'b0;
            end
            if (exec_go) begin
                pc_reg <= pc_next;
                rb_reg <= rb_next; rc_reg <= rc_next; rd_reg <= rd_next; re_reg <= re_next;
                rh_reg <= rh_next; rl_reg <= rl_next; rf_reg <= rf_next; ra_reg <= ra_next;
                alt_a_reg <= alt_a_next; alt_f_reg <= alt_f_next;
                phase_reg <= phase_next; op_reg <= op_next; imm_reg <= imm_next;
                pfx_reg <= pfx_next; stop_reg <= stop_next;
                out_kind_reg <= kind_c; out_addr_reg <= addr_c; out_data_reg <= data_c;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ bench/z80_subset_core_bus_step_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// z80_subset_core_bus_step_unit_test: self-checking bench for the bus step core
// The bench plays the memory and I/O side of a small Z80 subset core. It
// answers every bus request with a byte, chosen from its own model of the
// core so that most of the run is well-formed instructions with random
// operands. Each request is predicted and every result transaction is checked.
// ----------------------------------------------------------------------------
module z80_subset_core_bus_step_unit_test;
    import zsc_pkg::*;

    // Register file slots, in the order the core keeps them.
    localparam int R_B = 0, R_C = 1, R_D = 2, R_E = 3, R_H = 4, R_L = 5, R_F = 6, R_A = 7;

    // Opcodes of the supported subset and one outside it.
    localparam logic [7:0] OP_NOP = 8'h00, OP_LD_BC_NN = 8'h01, OP_LD_BCI_A = 8'h02,
        OP_INC_BC = 8'h03, OP_INC_B = 8'h04, OP_DEC_B = 8'h05, OP_LD_B_N = 8'h06,
        OP_RLCA = 8'h07, OP_EX_AF = 8'h08, OP_ADD_HL_BC = 8'h09, OP_LD_A_BCI = 8'h0a,
        OP_DEC_BC = 8'h0b, OP_INC_C = 8'h0c, OP_DEC_C = 8'h0d, OP_LD_C_N = 8'h0e,
        OP_RRCA = 8'h0f, OP_DJNZ = 8'h10, OP_LD_DE_NN = 8'h11, OP_LD_DEI_A = 8'h12,
        OP_INC_DE = 8'h13, OP_INC_D = 8'h14, OP_DEC_D = 8'h15, OP_LD_D_N = 8'h16,
        OP_RLA = 8'h17, OP_JR = 8'h18, OP_ADD_HL_DE = 8'h19, OP_JR_Z = 8'h28,
        OP_LD_NN_A = 8'h32, OP_LD_A_N = 8'h3e, OP_HALT = 8'h76, OP_OR_A = 8'hb7,
        OP_OUT = 8'hd3, OP_IN = 8'hdb, OP_CP_N = 8'hfe, OP_DAA = 8'h27;
    localparam logic [7:0] PRE_CB = 8'hcb, PRE_DD = 8'hdd, PRE_FD = 8'hfd, PRE_ED = 8'hed;

    typedef struct packed {
        req_kind_t   kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  flags;
    } bus_req_t;

    // Model of the core plus the queue of bus requests it still owes.
    class bus_step_scoreboard;
        logic [15:0] start_pc, pc;
        logic [7:0]  r [8];
        logic [7:0]  alt_a, alt_f, opc, imm;
        phase_t      ph;
        prefix_t     pfx;
        stop_t       st;
        bus_req_t    req;
        bus_req_t    pending [$];
        int          errors;

        function new();
            start_pc = 16'h0000;
            pc = 16'h0000;
            foreach (r[i]) r[i] = 8'h00;
            alt_a = 8'h00; alt_f = 8'h00; opc = 8'h00; imm = 8'h00;
            ph = PH_IDLE; pfx = PFX_NONE; st = STOP_RUN; errors = 0;
        endfunction

        function void emit(req_kind_t k, logic [15:0] addr, logic [7:0] data);
            req = '{k, addr, data, pc, r[R_A], r[R_F]};
        endfunction

        function void fetch(phase_t next);
            logic [15:0] addr;
            addr = pc;
            pc = pc + 16'd1;
            ph = next;
            emit(KIND_FETCH, addr, 8'h00);
        endfunction

        function void stop_core(stop_t why);
            st = why;
            emit(why == STOP_HALT ? KIND_HALTED : KIND_ERROR, 16'h0000, 8'h00);
        endfunction

        function logic [7:0] inc8(logic [7:0] v);
            r[R_F][FH]  = (v[3:0] == 4'hf);
            r[R_F][FPV] = (v == 8'h7f);
            v = v + 8'd1;
            r[R_F][FN] = 1'b0;
            r[R_F][FZ] = (v == 8'h00);
            r[R_F][FS] = v[7];
            return v;
        endfunction

        function logic [7:0] dec8(logic [7:0] v);
            v = v - 8'd1;
            r[R_F][FPV] = (v == 8'h7f);
            r[R_F][FH]  = (v[3:0] == 4'hf);
            r[R_F][FN]  = 1'b1;
            r[R_F][FZ]  = (v == 8'h00);
            r[R_F][FS]  = v[7];
            return v;
        endfunction

        function void add_hl(logic [15:0] b);
            logic [15:0] a;
            logic [16:0] s;
            a = {r[R_H], r[R_L]};
            s = a + b;
            r[R_F][FC] = s[16];
            r[R_F][FN] = 1'b0;
            r[R_F][FH] = a[12] ^ b[12] ^ s[12];
            {r[R_H], r[R_L]} = s[15:0];
        endfunction

        function void rot_flags(logic c);
            r[R_F][FC] = c;
            r[R_F][FN] = 1'b0;
            r[R_F][FH] = 1'b0;
        endfunction

        function void compare(logic [7:0] v);
            logic [7:0] a, d;
            a = r[R_A];
            d = a - v;
            r[R_F][FC]  = (a < v);
            r[R_F][FH]  = (a[3:0] < v[3:0]);
            r[R_F][FN]  = 1'b1;
            r[R_F][FZ]  = (d == 8'h00);
            r[R_F][FPV] = a[7] ^ v[7] && a[7] ^ d[7];
            r[R_F][FS]  = d[7];
        endfunction

        function void execute(logic [7:0] op);
            logic [7:0] a, t;
            a = r[R_A];
            opc = op;
            case (op)
                OP_NOP: ;
                OP_LD_BCI_A: begin
                    ph = PH_WRDONE; emit(KIND_MEMWR, {r[R_B], r[R_C]}, a); return;
                end
                OP_LD_DEI_A: begin
                    ph = PH_WRDONE; emit(KIND_MEMWR, {r[R_D], r[R_E]}, a); return;
                end
                OP_LD_A_BCI: begin
                    ph = PH_MEMRD; emit(KIND_MEMRD, {r[R_B], r[R_C]}, 8'h00); return;
                end
                OP_INC_BC: {r[R_B], r[R_C]} = {r[R_B], r[R_C]} + 16'd1;
                OP_DEC_BC: {r[R_B], r[R_C]} = {r[R_B], r[R_C]} - 16'd1;
                OP_INC_DE: {r[R_D], r[R_E]} = {r[R_D], r[R_E]} + 16'd1;
                OP_INC_B: r[R_B] = inc8(r[R_B]);
                OP_DEC_B: r[R_B] = dec8(r[R_B]);
                OP_INC_C: r[R_C] = inc8(r[R_C]);
                OP_DEC_C: r[R_C] = dec8(r[R_C]);
                OP_INC_D: r[R_D] = inc8(r[R_D]);
                OP_DEC_D: r[R_D] = dec8(r[R_D]);
                OP_RLCA: begin r[R_A] = {a[6:0], a[7]}; rot_flags(a[7]); end
                OP_RRCA: begin r[R_A] = {a[0], a[7:1]}; rot_flags(a[0]); end
                OP_RLA: begin r[R_A] = {a[6:0], r[R_F][FC]}; rot_flags(a[7]); end
                OP_EX_AF: begin
                    t = alt_a; alt_a = r[R_A]; r[R_A] = t;
                    t = alt_f; alt_f = r[R_F]; r[R_F] = t;
                end
                OP_ADD_HL_BC: add_hl({r[R_B], r[R_C]});
                OP_ADD_HL_DE: add_hl({r[R_D], r[R_E]});
                OP_OR_A: begin
                    r[R_F][FC] = 1'b0; r[R_F][FH] = 1'b0; r[R_F][FN] = 1'b0;
                    r[R_F][FZ] = (a == 8'h00);
                    r[R_F][FPV] = ~^a;
                    r[R_F][FS] = a[7];
                end
                OP_DJNZ: begin
                    r[R_B] = r[R_B] - 8'd1; fetch(PH_OP1); return;
                end
                OP_LD_BC_NN, OP_LD_B_N, OP_LD_C_N, OP_LD_DE_NN, OP_LD_D_N, OP_JR,
                OP_JR_Z, OP_LD_NN_A, OP_LD_A_N, OP_OUT, OP_IN, OP_CP_N: begin
                    fetch(PH_OP1); return;
                end
                OP_HALT: begin stop_core(STOP_HALT); return; end
                default: begin stop_core(STOP_ERROR); return; end
            endcase
            fetch(PH_OPC);
        endfunction

        function void operand1(logic [7:0] v);
            case (opc)
                OP_LD_BC_NN: begin r[R_C] = v; fetch(PH_OP2); return; end
                OP_LD_DE_NN: begin r[R_E] = v; fetch(PH_OP2); return; end
                OP_LD_NN_A: begin imm = v; fetch(PH_OP2); return; end
                OP_LD_B_N: r[R_B] = v;
                OP_LD_C_N: r[R_C] = v;
                OP_LD_D_N: r[R_D] = v;
                OP_LD_A_N: r[R_A] = v;
                OP_CP_N: compare(v);
                OP_DJNZ, OP_JR, OP_JR_Z: begin
                    if (opc == OP_JR || (opc == OP_DJNZ && r[R_B] != 8'h00) ||
                        (opc == OP_JR_Z && r[R_F][FZ]))
                        pc = pc + {{8{v[7]}}, v};
                end
                OP_OUT: begin
                    ph = PH_WRDONE; emit(KIND_IOWR, {r[R_A], v}, r[R_A]); return;
                end
                OP_IN: begin
                    ph = PH_IORD; emit(KIND_IORD, {r[R_A], v}, 8'h00); return;
                end
                default: begin stop_core(STOP_ERROR); return; end
            endcase
            fetch(PH_OPC);
        endfunction

        function void operand2(logic [7:0] v);
            case (opc)
                OP_LD_BC_NN: r[R_B] = v;
                OP_LD_DE_NN: r[R_D] = v;
                OP_LD_NN_A: begin
                    ph = PH_WRDONE; emit(KIND_MEMWR, {v, imm}, r[R_A]); return;
                end
                default: begin stop_core(STOP_ERROR); return; end
            endcase
            fetch(PH_OPC);
        endfunction

        function void opcode_byte(logic [7:0] b);
            if (b == PRE_CB || b == PRE_DD || b == PRE_FD || b == PRE_ED) begin
                if (pfx == PFX_NONE)
                    pfx = (b == PRE_DD || b == PRE_FD) ? PFX_IDX : PFX_CBED;
                else if (pfx == PFX_IDX && b == PRE_CB)
                    pfx = PFX_DISP;
                else
                    pfx = PFX_DONE;
                fetch(PH_OPC);
            end else if (pfx == PFX_DISP) begin
                pfx = PFX_DONE;
                fetch(PH_OPC);
            end else if (pfx != PFX_NONE) begin
                stop_core(STOP_ERROR);
            end else begin
                execute(b);
            end
        endfunction

        // An answer byte has been taken by the core: work out its next request.
        function void note_input(logic [7:0] b);
            if (st != STOP_RUN) begin
                stop_core(st);
            end else begin
                case (ph)
                    PH_IDLE: begin pc = start_pc; pfx = PFX_NONE; fetch(PH_OPC); end
                    PH_OPC: opcode_byte(b);
                    PH_OP1: operand1(b);
                    PH_OP2: operand2(b);
                    PH_MEMRD, PH_IORD: begin r[R_A] = b; fetch(PH_OPC); end
                    PH_WRDONE: fetch(PH_OPC);
                    default: stop_core(STOP_ERROR);
                endcase
            end
            pending.push_back(req);
        endfunction

        function void check_result(bus_req_t got);
            bus_req_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected request kind %0d addr %h", $time, got.kind, got.addr);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind) begin
                $display("%0t: req_kind expected %0d got %0d", $time, exp.kind, got.kind);
                errors++;
            end
            if (got.addr !== exp.addr) begin
                $display("%0t: req_addr expected %h got %h", $time, exp.addr, got.addr);
                errors++;
            end
            if (got.data !== exp.data) begin
                $display("%0t: req_data expected %h got %h", $time, exp.data, got.data);
                errors++;
            end
            if (got.pc !== exp.pc) begin
                $display("%0t: pc_now expected %h got %h", $time, exp.pc, got.pc);
                errors++;
            end
            if (got.acc !== exp.acc) begin
                $display("%0t: acc_now expected %h got %h", $time, exp.acc, got.acc);
                errors++;
            end
            if (got.flags !== exp.flags) begin
                $display("%0t: flags_now expected %h got %h", $time, exp.flags, got.flags);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tuser;
    logic [63:0] m_tdata;

    bus_step_scoreboard bus_model = new();
    logic [7:0] program_bytes [$];    // directed instruction stream, consumed at fetches
    bit         no_gaps = 1'b0;

    logic [7:0] legal_ops [33] = '{OP_NOP, OP_LD_BC_NN, OP_LD_BCI_A, OP_INC_BC, OP_INC_B,
        OP_DEC_B, OP_LD_B_N, OP_RLCA, OP_EX_AF, OP_ADD_HL_BC, OP_LD_A_BCI, OP_DEC_BC,
        OP_INC_C, OP_DEC_C, OP_LD_C_N, OP_RRCA, OP_DJNZ, OP_LD_DE_NN, OP_LD_DEI_A,
        OP_INC_DE, OP_INC_D, OP_DEC_D, OP_LD_D_N, OP_RLA, OP_JR, OP_ADD_HL_DE, OP_JR_Z,
        OP_LD_NN_A, OP_LD_A_N, OP_OR_A, OP_OUT, OP_IN, OP_CP_N};

    z80_subset_core_bus_step_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // The result side stalls at random with a chance of roughly nine in a hundred, except
    // during the window in which the bench asks for full throughput.
    always @(negedge aclk) begin
        m_tready <= no_gaps || ($urandom_range(99) >= 9);
    end

    // Every accepted result transaction is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            bus_model.check_result('{req_kind_t'(m_tuser[2:0]), m_tdata[15:0],
                m_tdata[23:16], m_tdata[39:24], m_tdata[47:40], m_tdata[55:48]});
    end

    // Writes the start address; only done while the core has nothing in flight.
    task automatic write_start_pc(input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        bus_model.start_pc = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Lets every outstanding request drain and allows for the core's latency.
    task automatic drain;
        s_tvalid = 1'b0;
        while (bus_model.pending.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Picks the answer to the request the core has just made. Opcode and
    // operand fetches take the directed stream first; otherwise a legal
    // instruction is chosen, with operands biased towards the interesting
    // cases (compare equal to the accumulator, short loop counts).
    function automatic logic [7:0] answer_byte();
        if (bus_model.ph inside {PH_OPC, PH_OP1, PH_OP2} && program_bytes.size() != 0)
            return program_bytes.pop_front();
        if (bus_model.ph == PH_OPC)
            return legal_ops[$urandom_range(32)];
        if (bus_model.ph == PH_OP1 && bus_model.opc == OP_CP_N && $urandom_range(2) == 0)
            return bus_model.r[R_A];
        if (bus_model.ph == PH_OP1 && bus_model.opc == OP_LD_B_N && $urandom_range(1) == 0)
            return 8'($urandom_range(3));
        return 8'($urandom);
    endfunction

    task automatic send_answer;
        logic [7:0] b;
        if (!no_gaps && $urandom_range(99) < 9) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        b = answer_byte();
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        bus_model.note_input(b);
        @(negedge aclk);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Start near the top of memory so the pc wraps through 0xffff.
        write_start_pc(16'h0000);
        write_start_pc(16'hfffe);

        // Directed part: accumulator extremes and every operation of the subset except halt.
        program_bytes = '{OP_LD_A_N, 8'hff, OP_OR_A, OP_RLCA, OP_RRCA, OP_RLA,
            OP_CP_N, 8'h80, OP_LD_B_N, 8'h7f, OP_INC_B, OP_DEC_B, OP_DEC_C,
            OP_LD_BC_NN, 8'hff, 8'hff, OP_INC_BC, OP_DEC_BC, OP_ADD_HL_BC,
            OP_LD_DE_NN, 8'h00, 8'h80, OP_ADD_HL_DE, OP_ADD_HL_DE, OP_INC_DE, OP_EX_AF,
            OP_INC_C, OP_LD_C_N, 8'h00, OP_LD_D_N, 8'h0f, OP_INC_D, OP_DEC_D,
            OP_JR, 8'h80, OP_LD_B_N, 8'h01, OP_DJNZ, 8'h7f, OP_DJNZ, 8'h05,
            OP_OR_A, OP_JR_Z, 8'h10, OP_CP_N, 8'h00, OP_JR_Z, 8'hfe,
            OP_OUT, 8'h55, OP_IN, 8'haa, OP_LD_NN_A, 8'h34, 8'h12,
            OP_LD_BCI_A, OP_LD_DEI_A, OP_LD_A_BCI, OP_NOP};
        while (program_bytes.size() != 0) send_answer();

        // The start address only matters at the first step; writes in later
        // phases must still be taken without disturbing execution.
        drain();
        write_start_pc(16'hffff);

        for (int i = 0; i < 1300; i++) begin
            if (i == 650) begin
                drain();
                write_start_pc(16'($urandom));
            end
            no_gaps = (i >= 300 && i < 500);
            send_answer();
        end
        no_gaps = 1'b0;

        // Finish with one way of stopping the core, then confirm it stays stopped.
        case ($urandom_range(3))
            0: program_bytes = '{OP_HALT};
            1: program_bytes = '{OP_DAA};
            2: program_bytes = '{PRE_DD, PRE_CB, 8'h05, 8'h06};
            default: program_bytes = '{PRE_ED, 8'h44};
        endcase
        while (bus_model.ph != PH_OPC) send_answer();
        while (program_bytes.size() != 0) send_answer();
        repeat (8) send_answer();

        drain();
        repeat (10) @(negedge aclk);
        if (bus_model.errors == 0 && bus_model.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit: reports a failure and stops if the run has not finished first.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ z80_subset_core_bus_step_unit.f @@
src/zsc_pkg.sv
src/z80_subset_core_bus_step_unit.sv
bench/z80_subset_core_bus_step_unit_test.sv
